/* rtl/spq_pkg.sv */
// spq_pkg: shared types and constants of the sorted insert priority queue
// request and response payloads, status codes, controller states and commands
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int PRIO_W = 8;
    localparam int TAG_W  = 16;
    localparam int OCC_W  = 8;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_REMOVED  = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic              req_type;
        logic [PRIO_W-1:0] entry_priority;
        logic [TAG_W-1:0]  entry_tag;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] head_priority;
        logic [TAG_W-1:0]  head_tag;
        logic [OCC_W-1:0]  occupancy;
    } t_rsp;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_SH,
        S_INS_LAST,
        S_RM_HEAD,
        S_RM_SH,
        S_FINISH
    } t_state;

    typedef enum logic [2:0] {
        RA_ZERO,
        RA_ONE,
        RA_TOP,
        RA_DOWN,
        RA_UP
    } t_rd_sel;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_NEW_ABOVE,
        WR_NEW_HEAD,
        WR_SHIFT_DOWN
    } t_wr_sel;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_TOP,
        IDX_ONE,
        IDX_DEC,
        IDX_INC
    } t_idx_op;

    typedef struct packed {
        logic    load;
        t_rd_sel rd_sel;
        t_wr_sel wr_sel;
        t_idx_op idx_op;
        logic    cap_head;
        logic    commit;
    } t_cmd;

    typedef struct packed {
        logic req_remove;
        logic full;
        logic empty;
        logic gt;
        logic idx_zero;
        logic idx_last;
        logic count_one;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* rtl/spq_ram.sv */
// spq_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module spq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/spq_ctrl.sv */
// spq_ctrl: sequencer for insert scans and remove shifts
// depends on spq_pkg
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
    import spq_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_in_valid,
    output logic       o_in_ready,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.req_remove) begin
                        n_state = i_stat.empty ? S_FINISH : S_RM_HEAD;
                    end else if (i_stat.full) begin
                        n_state = S_FINISH;
                    end else if (i_stat.empty) begin
                        n_state = S_INS_LAST;
                    end else begin
                        n_state = S_INS_SH;
                    end
                end
            end
            S_INS_SH: begin
                if (!i_stat.gt) begin
                    n_state = S_FINISH;
                end else if (i_stat.idx_zero) begin
                    n_state = S_INS_LAST;
                end
            end
            S_INS_LAST: begin
                n_state = S_FINISH;
            end
            S_RM_HEAD: begin
                n_state = i_stat.count_one ? S_FINISH : S_RM_SH;
            end
            S_RM_SH: begin
                if (i_stat.idx_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_in_ready      = 1'b0;
        o_cmd.load      = 1'b0;
        o_cmd.rd_sel    = RA_ZERO;
        o_cmd.wr_sel    = WR_NONE;
        o_cmd.idx_op    = IDX_HOLD;
        o_cmd.cap_head  = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.req_remove) begin
                        o_cmd.rd_sel = RA_ZERO;
                    end else begin
                        o_cmd.rd_sel = RA_TOP;
                        o_cmd.idx_op = IDX_TOP;
                    end
                end
            end
            S_INS_SH: begin
                if (i_stat.gt) begin
                    o_cmd.wr_sel = WR_SHIFT_UP;
                    if (!i_stat.idx_zero) begin
                        o_cmd.rd_sel = RA_DOWN;
                        o_cmd.idx_op = IDX_DEC;
                    end
                end else begin
                    o_cmd.wr_sel = WR_NEW_ABOVE;
                end
            end
            S_INS_LAST: begin
                o_cmd.wr_sel = WR_NEW_HEAD;
            end
            S_RM_HEAD: begin
                o_cmd.cap_head = 1'b1;
                o_cmd.rd_sel   = RA_ONE;
                o_cmd.idx_op   = IDX_ONE;
            end
            S_RM_SH: begin
                o_cmd.wr_sel = WR_SHIFT_DOWN;
                if (!i_stat.idx_last) begin
                    o_cmd.rd_sel = RA_UP;
                    o_cmd.idx_op = IDX_INC;
                end
            end
            S_FINISH: begin
                o_cmd.commit = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/spq_dp.sv */
// spq_dp: slot ram, scan index, entry count, result and output registers
// depends on spq_pkg and spq_ram
`timescale 1ns / 1ps
`default_nettype none

module spq_dp
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_in_data,
    input  wire t_cmd i_cmd,
    output t_stat     o_stat,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = $bits(t_entry);

    t_req              r_req;
    logic [AW-1:0]     r_idx;
    logic [AW-1:0]     n_idx;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    t_status           r_status;
    logic [PRIO_W-1:0] r_hp;
    logic [TAG_W-1:0]  r_ht;
    logic              r_out_valid;
    t_rsp              r_out_data;

    logic [AW-1:0]     top_idx;
    logic [AW-1:0]     raddr;
    logic [AW-1:0]     waddr;
    logic              we;
    t_entry            wdata;
    t_entry            rdata;
    t_entry            new_entry;
    logic [EW-1:0]     rdata_raw;
    logic              full;
    logic              empty;

    assign top_idx = AW'(r_count - 1'b1);
    assign full    = (r_count == CW'(DEPTH));
    assign empty   = (r_count == '0);
    assign rdata   = t_entry'(rdata_raw);

    assign new_entry.prio = r_req.entry_priority;
    assign new_entry.tag  = r_req.entry_tag;

    // read address
    always_comb begin
        case (i_cmd.rd_sel)
            RA_ZERO: raddr = '0;
            RA_ONE:  raddr = AW'(1);
            RA_TOP:  raddr = top_idx;
            RA_DOWN: raddr = r_idx - 1'b1;
            RA_UP:   raddr = r_idx + 1'b1;
            default: raddr = '0;
        endcase
    end

    // write port
    always_comb begin
        we    = 1'b1;
        waddr = r_idx + 1'b1;
        wdata = rdata;
        case (i_cmd.wr_sel)
            WR_SHIFT_UP: begin
                waddr = r_idx + 1'b1;
                wdata = rdata;
            end
            WR_NEW_ABOVE: begin
                waddr = r_idx + 1'b1;
                wdata = new_entry;
            end
            WR_NEW_HEAD: begin
                waddr = '0;
                wdata = new_entry;
            end
            WR_SHIFT_DOWN: begin
                waddr = r_idx - 1'b1;
                wdata = rdata;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    spq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_raw)
    );

    // scan index
    always_comb begin
        case (i_cmd.idx_op)
            IDX_TOP:  n_idx = top_idx;
            IDX_ONE:  n_idx = AW'(1);
            IDX_DEC:  n_idx = r_idx - 1'b1;
            IDX_INC:  n_idx = r_idx + 1'b1;
            default:  n_idx = r_idx;
        endcase
    end

    // count after the request
    always_comb begin
        case (r_status)
            ST_INSERTED: n_count = r_count + 1'b1;
            ST_REMOVED:  n_count = r_count - 1'b1;
            default:     n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.load) begin
            r_req <= i_in_data;
            r_hp  <= '0;
            r_ht  <= '0;
            if (i_in_data.req_type == REQ_REMOVE) begin
                r_status <= empty ? ST_EMPTY : ST_REMOVED;
            end else begin
                r_status <= full ? ST_FULL : ST_INSERTED;
            end
        end else if (i_cmd.cap_head) begin
            r_hp <= rdata.prio;
            r_ht <= rdata.tag;
        end
        if (i_cmd.commit) begin
            r_out_data.status        <= r_status;
            r_out_data.head_priority <= r_hp;
            r_out_data.head_tag      <= r_ht;
            r_out_data.occupancy     <= OCC_W'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.req_remove = (i_in_data.req_type == REQ_REMOVE);
    assign o_stat.full       = full;
    assign o_stat.empty      = empty;
    assign o_stat.gt         = (rdata.prio > r_req.entry_priority);
    assign o_stat.idx_zero   = (r_idx == '0);
    assign o_stat.idx_last   = (r_idx == top_idx);
    assign o_stat.count_one  = (r_count == CW'(1));
    assign o_stat.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/sorted_insert_priority_queue_unit.sv */
// sorted_insert_priority_queue_unit: top level of the sorted insert priority queue
// depends on spq_pkg, spq_ctrl, spq_dp (which holds spq_ram)
//
//   channel   direction  handshake                 payload
//   request   in         i_in_valid / o_in_ready   i_in_data  (t_req)
//   response  out        o_out_valid / i_out_ready o_out_data (t_rsp)
//
// one request at a time; the slot ram has one write and one registered read port
// insert: shift greater entries up a slot from the top down, then write the new entry
// remove: capture the head, shift the rest down; full or empty requests only respond
// reset clears the entry count and output valid; slot contents need no clearing
// a response waiting in the output register stalls only the finish of the next request
`timescale 1ns / 1ps
`default_nettype none

module sorted_insert_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_data
);

    t_cmd  cmd;
    t_stat stat;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    spq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

/* rtl/spq_checker.sv */
// spq_checker: port level checks of the sorted insert priority queue
// depends on spq_pkg; bound to sorted_insert_priority_queue_unit
`timescale 1ns / 1ps
`default_nettype none

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = 128
) (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_data
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("response changed while stalled");

    // one request in flight after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("request taken while another is in flight");

    // rejected insert shows a full queue and no head
    a_full_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.occupancy == FULL_OCC && o_out_data.head_priority == '0
            && o_out_data.head_tag == '0)
        else $error("full response malformed");

    // empty remove shows nothing held and no head
    a_empty_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_EMPTY |->
            o_out_data.occupancy == '0 && o_out_data.head_priority == '0
            && o_out_data.head_tag == '0)
        else $error("empty response malformed");

    // an insert leaves at least one entry and reports no head
    a_insert_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_INSERTED |->
            o_out_data.head_priority == '0 && o_out_data.head_tag == '0
            && (DEPTH > 255 || o_out_data.occupancy != '0))
        else $error("insert response malformed");

endmodule

bind sorted_insert_priority_queue_unit spq_checker #(
    .DEPTH (DEPTH)
) u_spq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
